### src/dlvp_pkg.sv
// Shared constants for the direct-mapped load value predictor.
// Holds default sizes, configuration register indexes and mode codes.
// Used by direct_mapped_load_value_predictor_core.
`timescale 1ns / 1ps

package dlvp_pkg;

  // Default table geometry.
  localparam int DLVP_ENTRIES     = 1024;
  localparam int DLVP_HISTORY_MAX = 8;

  // Data and configuration widths.
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREDICTOR_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  // Predictor modes. The last one is contextual with no stride fallback or update.
  localparam logic [1:0] MODE_STRIDE       = 2'd0;
  localparam logic [1:0] MODE_CONTEXT      = 2'd1;
  localparam logic [1:0] MODE_HYBRID       = 2'd2;
  localparam logic [1:0] MODE_CONTEXT_ONLY = 2'd3;

  // Confidence counter limits.
  localparam logic [1:0] CONF_MAX       = 2'd3;
  localparam logic [1:0] CONF_CONFIDENT = 2'd2;

endpackage

### src/dlvp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the predictor's entry and history tables.
`timescale 1ns / 1ps

module dlvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/direct_mapped_load_value_predictor_core.sv
// Direct-mapped load value predictor: one load word in, one prediction word out.
// The address is reduced modulo ENTRIES (quotient estimate, remainder, final subtraction),
// then table read, evaluate, predict, a pattern search from pattern_length downward when
// the mode and history call for one, and write-back, from which out_valid is registered.
// A new word is taken only while idle; busy stays high until the cycle its result strobes.
// After reset a clearing pass zeroes every entry of the entry table (busy high).
// The result is shown for one cycle on out_valid; the receiver cannot stall.
`timescale 1ns / 1ps

module direct_mapped_load_value_predictor_core #(
  parameter int ENTRIES     = dlvp_pkg::DLVP_ENTRIES,
  parameter int HISTORY_MAX = dlvp_pkg::DLVP_HISTORY_MAX
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [dlvp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dlvp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              start,
  output logic                              busy,
  input  logic [31:0]                       in_load_address,
  input  logic signed [31:0]                in_loaded_value,
  output logic                              out_valid,
  output logic signed [31:0]                out_predicted_value,
  output logic                              out_prediction_made,
  output logic                              out_prediction_correct,
  output logic                              out_was_confident,
  output logic                              out_tag_hit
);

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW  = $clog2(HISTORY_MAX + 1);
  localparam int RW  = IW + 1;
  localparam int DW  = dlvp_pkg::DATA_W;
  localparam int MW  = 3 * DW + 2 + FW;
  localparam int HW  = DW * HISTORY_MAX;

  // Reciprocal of ENTRIES scaled by 2^32; the estimated quotient is low by at most one.
  localparam logic [32:0] RECIP_WIDE = 33'(64'h1_0000_0000 / 64'(ENTRIES));
  localparam logic [31:0] RECIP      = (RECIP_WIDE > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                       : RECIP_WIDE[31:0];

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_PRED = 3'd5;
  localparam logic [2:0] S_SRCH = 3'd6;
  localparam logic [2:0] S_WB   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [2:0]    step_r, step_nxt;

  logic [3:0] cfg_depth_r;
  logic [1:0] cfg_mode_r;
  logic [2:0] cfg_plen_r;

  logic [31:0]   addr_r, addr_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  logic          hit_r, hit_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [31:0]   snew_r, snew_nxt;
  logic [31:0]   sold_r, sold_nxt;
  logic [1:0]    conf_r, conf_nxt;
  logic [31:0]   hist_r [HISTORY_MAX];
  logic [31:0]   pred_r, pred_nxt;
  logic [2:0]    len_r, len_nxt;

  logic          ov_r, ov_nxt;
  logic [31:0]   opred_r, opred_nxt;
  logic          omade_r, omade_nxt;
  logic          ocorr_r, ocorr_nxt;
  logic          oconf_r, oconf_nxt;
  logic          ohit_r, ohit_nxt;

  logic          meta_we, hist_we;
  logic [IW-1:0] meta_waddr;
  logic [MW-1:0] meta_wdata, meta_rdata;
  logic [HW-1:0] hist_wdata, hist_rdata;

  logic [FW-1:0] depth_eff;
  logic          strides_eq;
  logic [63:0]   recip_prod;
  logic [31:0]   rem_diff;

  logic             srch_found;
  logic [31:0]      srch_val;
  logic [HISTORY_MAX-1:0] pos_match;

  logic [FW-1:0] keep;
  logic [HW-1:0] hist_ins;
  logic          correct;
  logic [1:0]    conf_upd;

  // Entry table: tag, strides, confidence and fill count.
  dlvp_ram #(.WIDTH(MW), .DEPTH(ENTRIES), .AW(IW)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (idx_r),
    .rdata (meta_rdata)
  );

  // History table: one row of HISTORY_MAX values per entry, newest in slot 0.
  dlvp_ram #(.WIDTH(HW), .DEPTH(ENTRIES), .AW(IW)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (idx_r),
    .wdata (hist_wdata),
    .raddr (idx_r),
    .rdata (hist_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_depth_r <= 4'd1;
      cfg_mode_r  <= dlvp_pkg::MODE_STRIDE;
      cfg_plen_r  <= 3'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dlvp_pkg::REG_HISTORY_DEPTH:  cfg_depth_r <= cfg_wdata;
        dlvp_pkg::REG_PREDICTOR_MODE: cfg_mode_r  <= cfg_wdata[1:0];
        dlvp_pkg::REG_PATTERN_LENGTH: cfg_plen_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Effective history depth, clamped to 1..HISTORY_MAX.
  always_comb begin
    if (cfg_depth_r == 4'd0) begin
      depth_eff = FW'(1);
    end else if (int'(cfg_depth_r) > HISTORY_MAX) begin
      depth_eff = FW'(HISTORY_MAX);
    end else begin
      depth_eff = FW'(cfg_depth_r);
    end
  end

  assign strides_eq = (snew_r == sold_r);

  // Address modulo ENTRIES: reciprocal quotient estimate, then the remainder,
  // which lies below twice ENTRIES and needs at most one subtraction.
  assign recip_prod = 64'(addr_r) * 64'(RECIP);
  assign rem_diff   = addr_r - quo_r * 32'(ENTRIES);

  // Pattern search for the current length: match per position, then the most
  // frequent successor value, ties to the one whose most recent match lies furthest back.
  always_comb begin
    logic [FW-1:0] cnt;
    logic [FW-1:0] best_cnt;
    logic          first;
    for (int i = 0; i < HISTORY_MAX; i++) begin
      pos_match[i] = ((i + int'(len_r)) < int'(depth_eff)) &&
                     ((i + int'(len_r)) < int'(fill_r));
      for (int j = 0; j < HISTORY_MAX; j++) begin
        if (j < int'(len_r) && (i + 1 + j) < HISTORY_MAX) begin
          if (hist_r[i + 1 + j] != hist_r[j]) begin
            pos_match[i] = 1'b0;
          end
        end
      end
    end
    srch_found = 1'b0;
    srch_val   = '0;
    best_cnt   = '0;
    for (int i = 0; i < HISTORY_MAX; i++) begin
      cnt   = '0;
      first = 1'b1;
      for (int k = 0; k < HISTORY_MAX; k++) begin
        if (pos_match[k] && hist_r[k] == hist_r[i]) begin
          cnt = cnt + FW'(1);
          if (k < i) begin
            first = 1'b0;
          end
        end
      end
      if (pos_match[i] && first && (!srch_found || cnt >= best_cnt)) begin
        srch_found = 1'b1;
        srch_val   = hist_r[i];
        best_cnt   = cnt;
      end
    end
  end

  // History insertion and confidence update for write-back.
  always_comb begin
    keep = (fill_r < depth_eff - FW'(1)) ? fill_r : depth_eff - FW'(1);
    for (int i = 0; i < HISTORY_MAX; i++) begin
      if (i == 0) begin
        hist_ins[i*DW +: DW] = val_r;
      end else if (FW'(i) <= keep) begin
        hist_ins[i*DW +: DW] = hist_r[i-1];
      end else begin
        hist_ins[i*DW +: DW] = hist_r[i];
      end
    end
    correct = (fill_r != '0) && (pred_r == val_r);
    if (correct) begin
      conf_upd = (conf_r == dlvp_pkg::CONF_MAX) ? conf_r : conf_r + 2'd1;
    end else begin
      conf_upd = (conf_r == 2'd0) ? conf_r : conf_r - 2'd1;
    end
  end

  // Sequencer: clearing pass, modulo, table read, prediction and write-back.
  always_comb begin
    logic [FW-1:0] fill_wb;
    logic [31:0]   snew_wb;
    logic [31:0]   sold_wb;
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    step_nxt   = step_r;
    addr_nxt   = addr_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    hit_nxt    = hit_r;
    fill_nxt   = fill_r;
    snew_nxt   = snew_r;
    sold_nxt   = sold_r;
    conf_nxt   = conf_r;
    pred_nxt   = pred_r;
    len_nxt    = len_r;
    ov_nxt     = 1'b0;
    opred_nxt  = opred_r;
    omade_nxt  = omade_r;
    ocorr_nxt  = ocorr_r;
    oconf_nxt  = oconf_r;
    ohit_nxt   = ohit_r;
    meta_we    = 1'b0;
    hist_we    = 1'b0;
    meta_waddr = idx_r;
    meta_wdata = '0;
    hist_wdata = hist_ins;
    fill_wb    = fill_r;
    snew_wb    = snew_r;
    sold_wb    = sold_r;
    case (state_r)
      S_CLR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        clr_nxt    = clr_r + IW'(1);
        if (clr_r == IW'(ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          addr_nxt  = in_load_address;
          val_nxt   = $unsigned(in_loaded_value);
          idx_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd0) begin
          quo_nxt = recip_prod[63:32];
        end else if (step_r == 3'd1) begin
          rem_nxt = rem_diff[RW-1:0];
        end else begin
          if (rem_r >= RW'(ENTRIES)) begin
            idx_nxt = IW'(rem_r - RW'(ENTRIES));
          end else begin
            idx_nxt = rem_r[IW-1:0];
          end
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // A different tag claims the entry with cleared state.
        hit_nxt = (meta_rdata[MW-1 -: DW] == addr_r);
        if (hit_nxt) begin
          snew_nxt = meta_rdata[MW-DW-1 -: DW];
          sold_nxt = meta_rdata[MW-2*DW-1 -: DW];
          conf_nxt = meta_rdata[FW+1 -: 2];
          fill_nxt = meta_rdata[FW-1:0];
        end else begin
          snew_nxt = '0;
          sold_nxt = '0;
          conf_nxt = '0;
          fill_nxt = '0;
        end
        state_nxt = S_PRED;
      end
      S_PRED: begin
        state_nxt = S_WB;
        if (fill_r == '0) begin
          pred_nxt = '0;
        end else if (cfg_mode_r == dlvp_pkg::MODE_STRIDE && strides_eq) begin
          pred_nxt = hist_r[0] + snew_r;
        end else if (depth_eff == FW'(1)) begin
          pred_nxt = hist_r[0];
        end else if (cfg_mode_r == dlvp_pkg::MODE_STRIDE) begin
          pred_nxt = '0;
        end else begin
          len_nxt   = cfg_plen_r;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (len_r == 3'd0) begin
          if (cfg_mode_r == dlvp_pkg::MODE_HYBRID && strides_eq) begin
            pred_nxt = hist_r[0] + snew_r;
          end else begin
            pred_nxt = hist_r[0];
          end
          state_nxt = S_WB;
        end else if (srch_found) begin
          pred_nxt  = srch_val;
          state_nxt = S_WB;
        end else begin
          len_nxt = len_r - 3'd1;
        end
      end
      S_WB: begin
        if ((cfg_mode_r == dlvp_pkg::MODE_STRIDE || cfg_mode_r == dlvp_pkg::MODE_HYBRID)
            && fill_r != '0) begin
          sold_wb = snew_r;
          snew_wb = val_r - hist_r[0];
        end
        if (!(depth_eff == FW'(1) && fill_r != '0)) begin
          fill_wb = keep + FW'(1);
        end
        meta_we    = 1'b1;
        hist_we    = 1'b1;
        meta_wdata = {addr_r, snew_wb, sold_wb, conf_upd, fill_wb};
        ov_nxt     = 1'b1;
        opred_nxt  = pred_r;
        omade_nxt  = (fill_r != '0);
        ocorr_nxt  = correct;
        oconf_nxt  = (conf_r >= dlvp_pkg::CONF_CONFIDENT);
        ohit_nxt   = hit_r;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      step_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    hit_r   <= hit_nxt;
    fill_r  <= fill_nxt;
    snew_r  <= snew_nxt;
    sold_r  <= sold_nxt;
    conf_r  <= conf_nxt;
    pred_r  <= pred_nxt;
    len_r   <= len_nxt;
    opred_r <= opred_nxt;
    omade_r <= omade_nxt;
    ocorr_r <= ocorr_nxt;
    oconf_r <= oconf_nxt;
    ohit_r  <= ohit_nxt;
    if (state_r == S_EVAL) begin
      for (int i = 0; i < HISTORY_MAX; i++) begin
        hist_r[i] <= hist_rdata[i*DW +: DW];
      end
    end
  end

  // Result word outputs.
  assign busy                   = (state_r != S_IDLE);
  assign out_valid              = ov_r;
  assign out_predicted_value    = $signed(opred_r);
  assign out_prediction_made    = omade_r;
  assign out_prediction_correct = ocorr_r;
  assign out_was_confident      = oconf_r;
  assign out_tag_hit            = ohit_r;

endmodule
